@@ rtl/core/hecc_pkg.sv @@
// Shared constants and position tables for the Hamming encode/check/correct unit.
`timescale 1ns / 1ps

package hecc_pkg;

  localparam int CODE_W    = 63;
  localparam int SYN_W     = 6;
  localparam int LEN_W     = 6;
  localparam int PAR_CNT_W = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

  // Largest message length served by each parity count (m <= 2^r - r - 1).
  localparam logic [LEN_W-1:0] MAX_LEN_R2 = LEN_W'(1);
  localparam logic [LEN_W-1:0] MAX_LEN_R3 = LEN_W'(4);
  localparam logic [LEN_W-1:0] MAX_LEN_R4 = LEN_W'(11);
  localparam logic [LEN_W-1:0] MAX_LEN_R5 = LEN_W'(26);

  localparam logic [PAR_CNT_W-1:0] PAR_CNT_2 = PAR_CNT_W'(2);
  localparam logic [PAR_CNT_W-1:0] PAR_CNT_3 = PAR_CNT_W'(3);
  localparam logic [PAR_CNT_W-1:0] PAR_CNT_4 = PAR_CNT_W'(4);
  localparam logic [PAR_CNT_W-1:0] PAR_CNT_5 = PAR_CNT_W'(5);
  localparam logic [PAR_CNT_W-1:0] PAR_CNT_6 = PAR_CNT_W'(6);

  // Zero-based codeword bit that carries data bit j (j-th non power of two position).
  function automatic logic [SYN_W-1:0] data_bit_idx(input int j);
    int cnt;
    logic [SYN_W-1:0] idx;
    cnt = 0;
    idx = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) begin
          idx = SYN_W'(p - 1);
        end
        cnt++;
      end
    end
    return idx;
  endfunction

  // Codeword bits whose 1-based position has bit b set.
  function automatic logic [CODE_W-1:0] group_mask(input int b);
    logic [CODE_W-1:0] mask;
    mask = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (((p >> b) & 1) != 0) begin
        mask[p-1] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

@@ rtl/core/hamming_encode_check_correct_unit.sv @@
// Hamming encoder with single-bit fault injection, syndrome check and correction.
`timescale 1ns / 1ps

// One message per cycle: a transaction is taken whenever start is high (busy is
// always low) and its result, after the input and result registers, is shown on
// the result ports for one cycle, marked by result_valid_o. The receiver cannot
// stall the unit, so results must be captured when the strobe is seen. The path
// is an input register, the XOR trees for encoding, flipping and syndrome, and a
// result register. data_length is written over the cfg channel, which is always
// ready, and should only change while no transaction is in flight.
module hamming_encode_check_correct_unit
  import hecc_pkg::*;
#(
  parameter int MAX_DATA_BITS = 57
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LEN_W-1:0]         cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [MAX_DATA_BITS-1:0] data_bits_i,
  input  logic [SYN_W-1:0]         flip_position_i,
  output logic                     result_valid_o,
  output logic [CODE_W-1:0]        codeword_o,
  output logic [CODE_W-1:0]        received_word_o,
  output logic [SYN_W-1:0]         syndrome_o,
  output logic                     error_found_o,
  output logic                     syndrome_out_of_range_o,
  output logic [CODE_W-1:0]        corrected_word_o,
  output logic [PAR_CNT_W-1:0]     parity_count_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_DATA_BITS);

  logic [LEN_W-1:0]         data_length_q;
  logic                     in_valid_q;
  logic [MAX_DATA_BITS-1:0] data_q;
  logic [SYN_W-1:0]         flip_q;

  logic [LEN_W-1:0]     m_eff;
  logic [PAR_CNT_W-1:0] r_cnt;
  logic [LEN_W-1:0]     n_len;
  logic [CODE_W-1:0]    placed;
  logic [CODE_W-1:0]    code_d;
  logic [CODE_W-1:0]    recv_d;
  logic [CODE_W-1:0]    corr_d;
  logic [SYN_W-1:0]     syn_d;
  logic                 oor_d;
  logic                 flip_en;

  logic                 out_valid_q;
  logic [CODE_W-1:0]    code_q;
  logic [CODE_W-1:0]    recv_q;
  logic [CODE_W-1:0]    corr_q;
  logic [SYN_W-1:0]     syn_q;
  logic                 oor_q;
  logic [PAR_CNT_W-1:0] r_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      data_length_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      data_q <= data_bits_i;
      flip_q <= flip_position_i;
    end
    if (in_valid_q) begin
      code_q <= code_d;
      recv_q <= recv_d;
      corr_q <= corr_d;
      syn_q  <= syn_d;
      oor_q  <= oor_d;
      r_q    <= r_cnt;
    end
  end

  // Length clamp and parity count
  always_comb begin
    if (data_length_q == '0) begin
      m_eff = LEN_W'(1);
    end else if (data_length_q > MaxLen) begin
      m_eff = MaxLen;
    end else begin
      m_eff = data_length_q;
    end
    if (m_eff <= MAX_LEN_R2) begin
      r_cnt = PAR_CNT_2;
    end else if (m_eff <= MAX_LEN_R3) begin
      r_cnt = PAR_CNT_3;
    end else if (m_eff <= MAX_LEN_R4) begin
      r_cnt = PAR_CNT_4;
    end else if (m_eff <= MAX_LEN_R5) begin
      r_cnt = PAR_CNT_5;
    end else begin
      r_cnt = PAR_CNT_6;
    end
    n_len = m_eff + LEN_W'(r_cnt);
  end

  // Encode, inject, check, correct
  always_comb begin
    placed = '0;
    for (int j = 0; j < MAX_DATA_BITS; j++) begin
      placed[data_bit_idx(j)] = data_q[j] & (LEN_W'(j) < m_eff);
    end
    code_d = placed;
    for (int b = 0; b < SYN_W; b++) begin
      code_d[(1 << b) - 1] = ^(placed & group_mask(b));
    end

    flip_en = (flip_q != '0) && (flip_q <= n_len);
    recv_d  = code_d;
    if (flip_en) begin
      recv_d = code_d ^ (CODE_W'(1) << (flip_q - SYN_W'(1)));
    end

    for (int b = 0; b < SYN_W; b++) begin
      syn_d[b] = ^(recv_d & group_mask(b));
    end
    oor_d  = syn_d > n_len;
    corr_d = recv_d;
    if ((syn_d != '0) && !oor_d) begin
      corr_d = recv_d ^ (CODE_W'(1) << (syn_d - SYN_W'(1)));
    end
  end

  assign result_valid_o          = out_valid_q;
  assign codeword_o              = code_q;
  assign received_word_o         = recv_q;
  assign syndrome_o              = syn_q;
  assign error_found_o           = syn_q != '0;
  assign syndrome_out_of_range_o = oor_q;
  assign corrected_word_o        = corr_q;
  assign parity_count_o          = r_q;

  // Every transaction is answered by a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##2 result_valid_o)
    else $error("result strobe missing two cycles after start");

  // A single injected flip is always undone
  a_corrects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (corrected_word_o == codeword_o) && !syndrome_out_of_range_o)
    else $error("single flip not corrected");

  // Syndrome flags an error exactly when the received word differs
  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> error_found_o == (received_word_o != codeword_o))
    else $error("error flag disagrees with received word");

  // At most one bit flipped between codeword and received word
  a_one_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $countones(received_word_o ^ codeword_o) <= 1)
    else $error("more than one bit flipped");

endmodule

@@ sim/hamming_encode_check_correct_unit_tb.sv @@
// Self-checking testbench for the Hamming encode, fault-inject, check and correct unit.
`timescale 1ns / 1ps

package hecc_tb_pkg;

  import hecc_pkg::*;

  localparam int DATA_W = 57;

  typedef struct packed {
    logic [CODE_W-1:0]    codeword;
    logic [CODE_W-1:0]    received_word;
    logic [SYN_W-1:0]     syndrome;
    logic                 error_found;
    logic                 syndrome_out_of_range;
    logic [CODE_W-1:0]    corrected_word;
    logic [PAR_CNT_W-1:0] parity_count;
  } hecc_result_t;

  class hecc_scoreboard;
    hecc_result_t     expected_q[$];
    logic [LEN_W-1:0] msg_len_reg;
    int               errors;
    int               printed;

    function new();
      msg_len_reg = LEN_RESET;
      errors      = 0;
      printed     = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      msg_len_reg = v;
    endfunction

    // Length after clamping to 1..DATA_W
    function int msg_bits();
      int m;
      m = int'(msg_len_reg);
      if (m < 1) m = 1;
      if (m > DATA_W) m = DATA_W;
      return m;
    endfunction

    function int parity_bits(int m);
      int r;
      r = 0;
      while ((1 << r) < m + r + 1) r++;
      return r;
    endfunction

    function int code_length();
      return msg_bits() + parity_bits(msg_bits());
    endfunction

    function int position_xor(logic [CODE_W-1:0] w, int n);
      int s;
      s = 0;
      for (int p = 1; p <= n; p++) begin
        if (w[p-1]) s = s ^ p;
      end
      return s;
    endfunction

    function hecc_result_t encode_and_correct(logic [DATA_W-1:0] d, logic [SYN_W-1:0] f);
      hecc_result_t     res;
      int               m;
      int               r;
      int               n;
      int               j;
      int               s;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] recv;
      logic [CODE_W-1:0] corr;
      m    = msg_bits();
      r    = parity_bits(m);
      n    = m + r;
      code = '0;
      j    = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          code[p-1] = d[j];
          j++;
        end
      end
      s = position_xor(code, n);
      for (int i = 0; i < r; i++) begin
        if (((s >> i) & 1) != 0) code[(1 << i) - 1] = 1'b1;
      end
      recv = code;
      if (f != '0 && int'(f) <= n) recv[f-1] = ~recv[f-1];
      s    = position_xor(recv, n);
      corr = recv;
      if (s != 0 && s <= n) corr[s-1] = ~corr[s-1];
      res.codeword              = code;
      res.received_word         = recv;
      res.syndrome              = SYN_W'(s);
      res.error_found           = (s != 0);
      res.syndrome_out_of_range = (s > n);
      res.corrected_word        = corr;
      res.parity_count          = PAR_CNT_W'(r);
      return res;
    endfunction

    function void note_input(logic [DATA_W-1:0] d, logic [SYN_W-1:0] f);
      expected_q.push_back(encode_and_correct(d, f));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [CODE_W-1:0] got, logic [CODE_W-1:0] exp);
      errors++;
      if (printed < 40) begin
        printed++;
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
      end
    endtask

    task check_result(hecc_result_t got);
      hecc_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", got.codeword, '0);
      end else begin
        exp = expected_q.pop_front();
        if (got.codeword !== exp.codeword)
          report_mismatch("codeword", got.codeword, exp.codeword);
        if (got.received_word !== exp.received_word)
          report_mismatch("received_word", got.received_word, exp.received_word);
        if (got.syndrome !== exp.syndrome)
          report_mismatch("syndrome", CODE_W'(got.syndrome), CODE_W'(exp.syndrome));
        if (got.error_found !== exp.error_found)
          report_mismatch("error_found", CODE_W'(got.error_found), CODE_W'(exp.error_found));
        if (got.syndrome_out_of_range !== exp.syndrome_out_of_range)
          report_mismatch("syndrome_out_of_range", CODE_W'(got.syndrome_out_of_range),
                          CODE_W'(exp.syndrome_out_of_range));
        if (got.corrected_word !== exp.corrected_word)
          report_mismatch("corrected_word", got.corrected_word, exp.corrected_word);
        if (got.parity_count !== exp.parity_count)
          report_mismatch("parity_count", CODE_W'(got.parity_count),
                          CODE_W'(exp.parity_count));
      end
    endtask

    task flush_check();
      while (expected_q.size() != 0) begin
        report_mismatch("transaction never answered", expected_q[0].codeword, '0);
        void'(expected_q.pop_front());
      end
    endtask
  endclass

endpackage

module hamming_encode_check_correct_unit_tb;

  import hecc_pkg::*;
  import hecc_tb_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LEN_W-1:0]     cfg_data_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [DATA_W-1:0]    data_bits_i = '0;
  logic [SYN_W-1:0]     flip_position_i = '0;
  logic                 result_valid_o;
  logic [CODE_W-1:0]    codeword_o;
  logic [CODE_W-1:0]    received_word_o;
  logic [SYN_W-1:0]     syndrome_o;
  logic                 error_found_o;
  logic                 syndrome_out_of_range_o;
  logic [CODE_W-1:0]    corrected_word_o;
  logic [PAR_CNT_W-1:0] parity_count_o;

  hecc_scoreboard codec_sb;
  int             sender_idle_pct = 0;

  hamming_encode_check_correct_unit u_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_data_i              (cfg_data_i),
    .start                   (start),
    .busy                    (busy),
    .data_bits_i             (data_bits_i),
    .flip_position_i         (flip_position_i),
    .result_valid_o          (result_valid_o),
    .codeword_o              (codeword_o),
    .received_word_o         (received_word_o),
    .syndrome_o              (syndrome_o),
    .error_found_o           (error_found_o),
    .syndrome_out_of_range_o (syndrome_out_of_range_o),
    .corrected_word_o        (corrected_word_o),
    .parity_count_o          (parity_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Observe every handshake at the edge that completes it
  always @(posedge clk_i) begin
    hecc_result_t got;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.codeword              = codeword_o;
        got.received_word         = received_word_o;
        got.syndrome              = syndrome_o;
        got.error_found           = error_found_o;
        got.syndrome_out_of_range = syndrome_out_of_range_o;
        got.corrected_word        = corrected_word_o;
        got.parity_count          = parity_count_o;
        codec_sb.check_result(got);
      end
      if (start && !busy) codec_sb.note_input(data_bits_i, flip_position_i);
      if (cfg_valid_i && cfg_ready_o) codec_sb.set_length(cfg_data_i);
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] d, input logic [SYN_W-1:0] f);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start           <= 1'b1;
    data_bits_i     <= d;
    flip_position_i <= f;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained(input int max_cycles);
    int waited;
    waited = 0;
    @(negedge clk_i);
    while (codec_sb.pending() != 0 && waited < max_cycles) begin
      @(negedge clk_i);
      waited++;
    end
  endtask

  // Length register only changes once every transaction has been answered
  task automatic write_len(input logic [LEN_W-1:0] v);
    start <= 1'b0;
    wait_drained(100000);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [DATA_W-1:0] d;
    logic [SYN_W-1:0]  f;
    int                sel;
    sel = $urandom_range(15);
    if (sel == 0) d = '0;
    else if (sel == 1) d = '1;
    else d = DATA_W'({$urandom, $urandom});
    sel = $urandom_range(7);
    if (sel == 0) f = '0;
    else if (sel < 6) f = SYN_W'($urandom_range(codec_sb.code_length(), 1));
    else f = SYN_W'($urandom_range(63));
    send_item(d, f);
  endtask

  initial begin
    int len_plan[15];
    codec_sb = new();
    len_plan = '{1, 0, 63, 57, 26, 27, 11, 12, 2, 5, 58, -1, -1, -1, -1};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Length 4 after reset: seven-bit code, every flip position
    send_item('0, '0);
    send_item('1, '0);
    for (int f = 1; f <= 7; f++) send_item(DATA_W'(f * 3), SYN_W'(f));
    send_item('1, SYN_W'(8));
    send_item(DATA_W'(10), SYN_W'(63));

    write_len(LEN_W'(57));
    send_item('0, '0);
    send_item('1, SYN_W'(63));
    send_item(DATA_W'(57'h0AA_AAAA_AAAA_AAAA), SYN_W'(32));
    send_item('1, SYN_W'(1));
    send_item(DATA_W'(57'h155_5555_5555_5555), '0);

    // Zero length behaves as one, oversize clamps to the maximum
    write_len('0);
    send_item(DATA_W'(1), SYN_W'(3));
    send_item('0, SYN_W'(4));
    write_len(LEN_W'(63));
    send_item('1, SYN_W'(63));
    send_item('0, SYN_W'(1));

    for (int ph = 0; ph < 15; ph++) begin
      if (len_plan[ph] < 0) write_len(LEN_W'($urandom_range(63)));
      else write_len(LEN_W'(len_plan[ph]));
      if (ph < 5) sender_idle_pct = 8;
      else if (ph < 10) sender_idle_pct = 86;
      else sender_idle_pct = 0;
      repeat (90) random_item();
    end

    start <= 1'b0;
    wait_drained(1000);
    repeat (8) @(posedge clk_i);
    codec_sb.flush_check();
    if (codec_sb.errors == 0) begin
      $display("[hamming_encode_check_correct_unit] OK");
    end else begin
      $display("[hamming_encode_check_correct_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("[hamming_encode_check_correct_unit] ERROR");
    $finish;
  end

endmodule
